/* src/rgbcd_pkg.sv */
`timescale 1ns / 1ps

package rgbcd_pkg;

    localparam int RAD_W  = 20;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // floor(s / 3) == (s * RECIP3) >> RECIP3_SHIFT for every s below 2**19
    localparam logic [17:0] RECIP3       = 18'd174763;
    localparam int          RECIP3_SHIFT = 19;

    localparam logic [10:0] RED_WEIGHT_BASE  = 11'd1024;
    localparam logic [10:0] BLUE_WEIGHT_BASE = 11'd1534;

    localparam logic MODE_EUCLID  = 1'b0;
    localparam logic MODE_REDMEAN = 1'b1;

    localparam logic [7:0] GREY_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0] red_a;
        logic [7:0] green_a;
        logic [7:0] blue_a;
        logic [7:0] red_b;
        logic [7:0] green_b;
        logic [7:0] blue_b;
    } pixel_pair_t;

    typedef struct packed {
        logic [7:0] grey_level;
        logic       clipped;
    } grey_result_t;

    typedef struct packed {
        logic              valid;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_bus_t;

endpackage

/* src/rgbcd_front.sv */
`timescale 1ns / 1ps

module rgbcd_front
    import rgbcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        feed_valid,
    input  pixel_pair_t feed,
    input  logic        mode,
    output sqrt_bus_t   sqrt_in
);

    logic [3:0] valid_reg;

    logic [7:0]  dr_reg, dg_reg, db_reg;
    logic [8:0]  sr_reg;
    logic [15:0] dr2_reg, dg2_reg, db2_reg;
    logic [8:0]  sr2_reg;
    logic [17:0] esum_reg;
    logic [26:0] pr_reg, pb_reg;
    logic [15:0] dg2b_reg;
    logic [RAD_W-1:0] rad_reg;

    logic [7:0]  dr_next, dg_next, db_next;
    logic [8:0]  sr_next;
    logic [10:0] wr, wb;
    logic [35:0] prod3;
    logic [28:0] x_sum;
    logic [RAD_W-1:0] rad_next;

    always_comb
    begin
        dr_next = (feed.red_a > feed.red_b) ? feed.red_a - feed.red_b
                                            : feed.red_b - feed.red_a;
        dg_next = (feed.green_a > feed.green_b) ? feed.green_a - feed.green_b
                                                : feed.green_b - feed.green_a;
        db_next = (feed.blue_a > feed.blue_b) ? feed.blue_a - feed.blue_b
                                              : feed.blue_b - feed.blue_a;
        sr_next = {1'b0, feed.red_a} + {1'b0, feed.red_b};

        wr = RED_WEIGHT_BASE + {2'b00, sr2_reg};
        wb = BLUE_WEIGHT_BASE - {2'b00, sr2_reg};

        prod3 = {18'd0, esum_reg} * {18'd0, RECIP3};
        x_sum = {2'b00, pr_reg} + {2'b00, dg2b_reg, 11'd0} + {2'b00, pb_reg};

        if (mode == MODE_REDMEAN)
        begin
            rad_next = x_sum[28:9];
        end
        else
        begin
            rad_next = {4'd0, prod3[RECIP3_SHIFT+15:RECIP3_SHIFT]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], feed_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: channel differences
            dr_reg   <= dr_next;
            dg_reg   <= dg_next;
            db_reg   <= db_next;
            sr_reg   <= sr_next;
            // stage 2: squares
            dr2_reg  <= {8'd0, dr_reg} * {8'd0, dr_reg};
            dg2_reg  <= {8'd0, dg_reg} * {8'd0, dg_reg};
            db2_reg  <= {8'd0, db_reg} * {8'd0, db_reg};
            sr2_reg  <= sr_reg;
            // stage 3: plain sum and weighted terms
            esum_reg <= {2'b00, dr2_reg} + {2'b00, dg2_reg} + {2'b00, db2_reg};
            pr_reg   <= {16'd0, wr} * {11'd0, dr2_reg};
            pb_reg   <= {16'd0, wb} * {11'd0, db2_reg};
            dg2b_reg <= dg2_reg;
            // stage 4: radicand
            rad_reg  <= rad_next;
        end
    end

    assign sqrt_in.valid = valid_reg[3];
    assign sqrt_in.rad   = rad_reg;
    assign sqrt_in.rem   = '0;
    assign sqrt_in.root  = '0;

endmodule

/* src/rgbcd_sqrt_cell.sv */
`timescale 1ns / 1ps

module rgbcd_sqrt_cell
    import rgbcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  sqrt_bus_t up,
    output sqrt_bus_t down
);

    logic              valid_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // one root bit per cell: bring down two radicand bits, try 4*root+1
    always_comb
    begin
        cur   = {up.rem, up.rad[RAD_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W){1'b0}}, up.root, 2'b01};
        diff  = cur - trial;
        if (cur >= trial)
        begin
            rem_next  = diff[REM_W-1:0];
            root_next = {up.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = cur[REM_W-1:0];
            root_next = {up.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {up.rad[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign down.valid = valid_reg;
    assign down.rad   = rad_reg;
    assign down.rem   = rem_reg;
    assign down.root  = root_reg;

endmodule

/* src/rgb_color_distance_grey.sv */
`timescale 1ns / 1ps
// pipeline: 4 front stages, one square root cell per root bit (10 cells) and one
// output register
// throughput: one request per cycle while no result is held by res_stall; a one-entry
// input skid lets one more request in while a result waits on res_stall
// reset: rst_n clears all valid bits and selects the euclidean metric

module rgb_color_distance_grey
    import rgbcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pix_valid,
    output logic         pix_stall,
    input  pixel_pair_t  pix,
    output logic         res_valid,
    input  logic         res_stall,
    output grey_result_t res,
    input  logic         cfg_we,
    input  logic         cfg_wdata
);

    logic         mode_reg;
    logic         skid_valid_reg;
    pixel_pair_t  skid_reg;
    logic         res_valid_reg;
    grey_result_t res_reg;

    logic         en;
    logic         feed_valid;
    pixel_pair_t  feed;
    sqrt_bus_t    chain [0:ROOT_W];
    logic         clip;
    grey_result_t res_next;

    assign en         = !res_valid_reg || !res_stall;
    assign pix_stall  = skid_valid_reg;
    assign feed_valid = skid_valid_reg || pix_valid;
    assign feed       = skid_valid_reg ? skid_reg : pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_EUCLID;
            skid_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (en)
            begin
                skid_valid_reg <= 1'b0;
                res_valid_reg  <= chain[ROOT_W].valid;
            end
            else if (pix_valid && !skid_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && pix_valid && !skid_valid_reg)
        begin
            skid_reg <= pix;
        end
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    rgbcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .feed_valid (feed_valid),
        .feed       (feed),
        .mode       (mode_reg),
        .sqrt_in    (chain[0])
    );

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        rgbcd_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .up    (chain[i]),
            .down  (chain[i+1])
        );
    end

    always_comb
    begin
        clip                = |chain[ROOT_W].root[ROOT_W-1:8];
        res_next.clipped    = clip;
        res_next.grey_level = clip ? GREY_MAX : chain[ROOT_W].root[7:0];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* src/rgbcd_checker.sv */
`timescale 1ns / 1ps

module rgbcd_checker
    import rgbcd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         pix_valid,
    input logic         pix_stall,
    input pixel_pair_t  pix,
    input logic         res_valid,
    input logic         res_stall,
    input grey_result_t res,
    input logic         cfg_we,
    input logic         cfg_wdata
);

    logic mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_EUCLID;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.clipped |-> res.grey_level == GREY_MAX)
        else $error("clipped result not saturated");

    a_euclid_noclip: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && mode_reg == MODE_EUCLID |-> !res.clipped)
        else $error("euclidean result flagged clipped");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_stall) |-> $past(pix_valid) && $past(res_valid && res_stall))
        else $error("input stall raised without a held result");

endmodule

bind rgb_color_distance_grey rgbcd_checker u_rgbcd_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import rgbcd_pkg::*;

    class grey_scoreboard;
        grey_result_t expected_grey_q[$];
        logic         mode;
        int           mismatch_count;

        function new();
            mode = MODE_EUCLID;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_grey_q.size();
        endfunction

        // integer floor square root, radicand stays below 2**20
        function int unsigned floor_root(int unsigned radicand);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 10; b >= 0; b--)
            begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= radicand)
                    root = trial;
            end
            return int'(root);
        endfunction

        function grey_result_t grey_from_pixels(pixel_pair_t p);
            int unsigned     dr;
            int unsigned     dg;
            int unsigned     db;
            int unsigned     red_sum;
            int unsigned     radicand;
            int unsigned     root;
            longint unsigned weighted;
            grey_result_t    r;
            dr = (p.red_a > p.red_b) ? p.red_a - p.red_b : p.red_b - p.red_a;
            dg = (p.green_a > p.green_b) ? p.green_a - p.green_b : p.green_b - p.green_a;
            db = (p.blue_a > p.blue_b) ? p.blue_a - p.blue_b : p.blue_b - p.blue_a;
            if (mode == MODE_EUCLID)
            begin
                radicand = (dr * dr + dg * dg + db * db) / 3;
            end
            else
            begin
                red_sum = int'(p.red_a) + int'(p.red_b);
                weighted = longint'(1024 + red_sum) * (dr * dr)
                         + longint'(2048) * (dg * dg)
                         + longint'(1534 - red_sum) * (db * db);
                radicand = int'(weighted / 512);
            end
            root = floor_root(radicand);
            if (root > 255)
            begin
                r.grey_level = GREY_MAX;
                r.clipped    = 1'b1;
            end
            else
            begin
                r.grey_level = root[7:0];
                r.clipped    = 1'b0;
            end
            return r;
        endfunction

        function void note_request(pixel_pair_t p);
            expected_grey_q.push_back(grey_from_pixels(p));
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_result(grey_result_t r);
            grey_result_t want;
            if (expected_grey_q.size() == 0)
            begin
                report($sformatf("result grey %0d clipped %0d with nothing expected",
                                 r.grey_level, r.clipped));
            end
            else
            begin
                want = expected_grey_q.pop_front();
                if (r.grey_level !== want.grey_level)
                    report($sformatf("grey_level %0d, expected %0d",
                                     r.grey_level, want.grey_level));
                if (r.clipped !== want.clipped)
                    report($sformatf("clipped %0d, expected %0d", r.clipped, want.clipped));
            end
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         pix_valid = 1'b0;
    logic         pix_stall;
    pixel_pair_t  pix = '0;
    logic         res_valid;
    logic         res_stall = 1'b0;
    grey_result_t res;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;

    grey_scoreboard sb;
    bit             idle_on = 1'b1;

    rgb_color_distance_grey dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // values read here are the ones present just before the edge
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res);
    end

    // receiver back-pressure in bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    task send_pixel(pixel_pair_t p);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (pix_stall);
        sb.note_request(p);
    endtask

    task write_mode(logic m);
        while (sb.pending() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we  <= 1'b0;
        sb.mode = m;
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_pair_t pick_pair();
        pixel_pair_t p;
        p.red_a   = pick_channel();
        p.green_a = pick_channel();
        p.blue_a  = pick_channel();
        case ($urandom_range(0, 3))
            // nearby colors, small differences
            0:
            begin
                p.red_b   = p.red_a + 8'($urandom_range(0, 6)) - 8'd3;
                p.green_b = p.green_a + 8'($urandom_range(0, 6)) - 8'd3;
                p.blue_b  = p.blue_a + 8'($urandom_range(0, 6)) - 8'd3;
            end
            // complementary colors, pushes redmean into saturation
            1:
            begin
                p.red_b   = ~p.red_a;
                p.green_b = ~p.green_a;
                p.blue_b  = ~p.blue_a;
            end
            default:
            begin
                p.red_b   = pick_channel();
                p.green_b = pick_channel();
                p.blue_b  = pick_channel();
            end
        endcase
        return p;
    endfunction

    pixel_pair_t edge_pairs[$];

    initial
    begin
        int          sent;
        int          burst;
        logic        next_mode;
        pixel_pair_t p;

        rst_n = 1'b0;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        edge_pairs = '{
            '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
            '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
            '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0},
            '{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255},
            '{8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
            '{8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0},
            '{8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0},
            '{8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255},
            // redmean just below and just above the saturation point
            '{8'd0,   8'd127, 8'd0,   8'd0,   8'd0,   8'd0},
            '{8'd0,   8'd128, 8'd0,   8'd0,   8'd0,   8'd0},
            '{8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6},
            '{8'd255, 8'd0,   8'd0,   8'd254, 8'd0,   8'd0}
        };

        // directed items in the reset mode first, then in redmean
        foreach (edge_pairs[i])
            send_pixel(edge_pairs[i]);
        pix_valid <= 1'b0;
        write_mode(MODE_REDMEAN);
        foreach (edge_pairs[i])
            send_pixel(edge_pairs[i]);
        pix_valid <= 1'b0;

        sent = 0;
        next_mode = MODE_EUCLID;
        while (sent < 1900)
        begin
            burst = $urandom_range(60, 250);
            if (burst > 1900 - sent)
                burst = 1900 - sent;
            idle_on = (1900 - sent > 300) ? ($urandom_range(0, 4) != 0) : 1'b0;
            write_mode(next_mode);
            repeat (burst)
            begin
                p = pick_pair();
                send_pixel(p);
            end
            pix_valid <= 1'b0;
            sent += burst;
            next_mode = ($urandom_range(0, 2) == 0) ? next_mode : ~next_mode;
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        if (sb.mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
